// ===== src/btmx_pkg.sv =====
// ----------------------------------------------------------------------------
// btmx_pkg: shared types for the maximum-xor trie
// action codes, request and result structs
// ----------------------------------------------------------------------------
package btmx_pkg;

	localparam int FIELD_W = 32;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_QUERY  = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [FIELD_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] match_value;
		logic               found;
		logic               dropped;
	} rsp_t;

endpackage

// ===== src/btmx_ram.sv =====
// ----------------------------------------------------------------------------
// btmx_ram: generic single-port ram
// one write or read per cycle, registered read data
// ----------------------------------------------------------------------------
module btmx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== src/btmx_cell.sv =====
// ----------------------------------------------------------------------------
// btmx_cell: one trie level
// holds the key bit of its level, picks the next node from the link entry of
// the current node and hands the walk to the next level
// ----------------------------------------------------------------------------
module btmx_cell #(
	parameter int NW = 17
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            kbit,
	input  logic            is_ins,
	input  logic            tok_in,
	input  logic [NW-1:0]   node_in,
	input  logic            grown_in,
	input  logic [2*NW-1:0] ent,
	input  logic [NW-1:0]   new_node,
	output logic            tok_out,
	output logic [NW-1:0]   node_out,
	output logic            grown_out,
	output logic            wr,
	output logic [NW-1:0]   addr,
	output logic [2*NW-1:0] wdata
);
	logic          tok_q, kb_q, grown_q;
	logic [NW-1:0] node_q;
	logic [NW-1:0] c_b, c_nb, other;
	logic          grow;

	assign c_b  = kb_q ? ent[2*NW-1:NW] : ent[NW-1:0];
	assign c_nb = kb_q ? ent[NW-1:0] : ent[2*NW-1:NW];
	// a fresh node has no children, so below it every level allocates
	assign grow  = is_ins && (grown_q || c_b == '0);
	assign other = grown_q ? '0 : c_nb;

	always_comb begin
		if (!is_ins) begin
			node_out = (c_nb != '0) ? c_nb : c_b;
		end else if (grow) begin
			node_out = new_node;
		end else begin
			node_out = c_b;
		end
	end

	assign tok_out   = tok_q;
	assign grown_out = grow;
	assign wr        = tok_q && grow;
	// a growing level writes its own node, otherwise the child is read
	assign addr  = !tok_q ? '0 : (grow ? node_q : node_out);
	assign wdata = !tok_q ? '0 : (kb_q ? {new_node, other} : {other, new_node});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		node_q  <= node_in;
		grown_q <= grown_in;
		if (load) begin
			kb_q <= kbit;
		end
	end
endmodule

// ===== src/binary_trie_max_xor_core.sv =====
// ----------------------------------------------------------------------------
// binary_trie_max_xor_core: maximum-xor query trie
// ----------------------------------------------------------------------------
// A transaction walks the trie from the root down through a chain of KEY_BITS
// level cells, one level per cycle, sharing a link memory and a leaf memory
// with registered read data; the root links live in registers and fresh
// nodes come from a counter. An insert or query passes through every level
// cell in order and then reads or writes the leaf memory before its result
// strobe. A clear, an unused action, a refused insert or a query on an
// empty trie strobes in the cycle after acceptance. busy stays high until
// the one-cycle result strobe has ended, so the next transaction can be
// accepted only after it; the receiver cannot stall. An insert is refused
// while fewer than KEY_BITS nodes of the MAX_KEYS*KEY_BITS pool are free.
// No clearing pass is needed after reset.
module binary_trie_max_xor_core #(
	parameter int KEY_BITS = 32,
	parameter int MAX_KEYS = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  btmx_pkg::req_t    req,
	output logic              busy,
	output logic              done,
	output btmx_pkg::rsp_t    rsp
);
	import btmx_pkg::*;

	localparam int POOL = MAX_KEYS * KEY_BITS;
	localparam int NW   = $clog2(POOL);

	logic [KEY_BITS-1:0] kext;
	logic [FIELD_W-1:0]  key_q;
	logic [1:0]          act_q;
	logic                run_q, fin_q, ne_q;
	logic [NW-1:0]       nf_q, new_node, leaf_node_q, addr;
	logic [2*NW-1:0]     root_q, link_rd, link_wd;
	logic [FIELD_W-1:0]  leaf_rd;
	logic                acc, go, full, is_ins, link_we, leaf_we, grow_any;
	logic                tk_w [KEY_BITS+1];
	logic [NW-1:0]       nd_w [KEY_BITS+1];
	logic                gr_w [KEY_BITS+1];
	logic [NW-1:0]       areq [KEY_BITS];
	logic [2*NW-1:0]     wreq [KEY_BITS];
	logic [NW-1:0]       a_or [KEY_BITS+1];
	logic [2*NW-1:0]     d_or [KEY_BITS+1];
	logic [KEY_BITS-1:0] tok_v, wr_v;

	assign acc    = start && !busy;
	assign busy   = run_q || done;
	assign is_ins = act_q == ACT_INSERT;
	assign kext   = KEY_BITS'(req.key);
	// refuse while fewer than KEY_BITS nodes are free besides the root
	assign full = (32'(nf_q) + 32'(KEY_BITS)) > 32'(POOL - 1);
	assign go   = acc && ((req.action == ACT_INSERT && !full) ||
	                      (req.action == ACT_QUERY && ne_q));
	assign new_node = nf_q + NW'(1);

	assign tk_w[0] = go;
	assign nd_w[0] = '0;
	assign gr_w[0] = 1'b0;
	assign a_or[0] = fin_q ? leaf_node_q : '0;
	assign d_or[0] = '0;

	for (genvar g = 0; g < KEY_BITS; g++) begin : g_lvl
		btmx_cell #(.NW(NW)) u_cell (
			.clk(clk), .arst_n(arst_n), .load(acc), .kbit(kext[KEY_BITS-1-g]),
			.is_ins(is_ins), .tok_in(tk_w[g]), .node_in(nd_w[g]), .grown_in(gr_w[g]),
			.ent(g == 0 ? root_q : link_rd), .new_node(new_node),
			.tok_out(tk_w[g+1]), .node_out(nd_w[g+1]), .grown_out(gr_w[g+1]),
			.wr(wr_v[g]), .addr(areq[g]), .wdata(wreq[g])
		);
		assign tok_v[g]  = tk_w[g+1];
		assign a_or[g+1] = a_or[g] | areq[g];
		// the root level writes the root registers, not the memory
		assign d_or[g+1] = (g == 0) ? d_or[g] : (d_or[g] | wreq[g]);
	end

	assign grow_any = |wr_v;
	assign link_we  = |wr_v[KEY_BITS-1:1];
	assign link_wd  = d_or[KEY_BITS];
	assign addr     = a_or[KEY_BITS];
	assign leaf_we  = fin_q && is_ins;

	btmx_ram #(.WIDTH(2*NW), .DEPTH(POOL)) u_links (
		.clk(clk), .we(link_we), .addr(addr), .wdata(link_wd), .rdata(link_rd)
	);

	btmx_ram #(.WIDTH(FIELD_W), .DEPTH(POOL)) u_leaf (
		.clk(clk), .we(leaf_we), .addr(addr), .wdata(key_q), .rdata(leaf_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done   <= 1'b0;
			ne_q   <= 1'b0;
			nf_q   <= '0;
			root_q <= '0;
			rsp    <= '0;
		end else begin
			fin_q <= tk_w[KEY_BITS];
			if (acc) begin
				run_q <= go;
				done  <= !go;
				rsp.match_value <= '0;
				rsp.found       <= 1'b0;
				rsp.dropped     <= req.action == ACT_INSERT && full;
				if (req.action == ACT_CLEAR) begin
					ne_q   <= 1'b0;
					nf_q   <= '0;
					root_q <= '0;
				end
			end else if (fin_q) begin
				run_q <= 1'b0;
				done  <= 1'b1;
				rsp.match_value <= is_ins ? '0 : leaf_rd;
				rsp.found       <= !is_ins;
				rsp.dropped     <= 1'b0;
				if (is_ins) begin
					ne_q <= 1'b1;
				end
			end else begin
				done <= 1'b0;
				if (wr_v[0]) begin
					root_q <= wreq[0];
				end
				if (grow_any) begin
					nf_q <= new_node;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		leaf_node_q <= nd_w[KEY_BITS];
		if (acc) begin
			key_q <= FIELD_W'(kext);
			act_q <= req.action;
		end
	end

`ifndef ASSERT_OFF
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");
	a_one_level: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(tok_v))
		else $error("more than one level active");
	a_drop_ins: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.dropped |-> act_q == ACT_INSERT)
		else $error("drop on non-insert");
	a_found_query: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.found |-> act_q == ACT_QUERY)
		else $error("found on non-query");
`endif
endmodule

// ===== sim/binary_trie_max_xor_core_tb.sv =====
// ----------------------------------------------------------------------------
// binary_trie_max_xor_core_tb: self-checking bench for the maximum-xor trie
// directed table of edge cases, then random insert/query/clear/unused-action traffic with
// random start gaps; every result strobe is checked against a trie predictor
// ----------------------------------------------------------------------------
module binary_trie_max_xor_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import btmx_pkg::*;

	localparam int KEY_BITS   = 32;
	localparam int MAX_KEYS   = 4096;
	localparam int POOL_NODES = MAX_KEYS * KEY_BITS;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	binary_trie_max_xor_core #(.KEY_BITS(KEY_BITS), .MAX_KEYS(MAX_KEYS)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the trie
	int unsigned trie_links[POOL_NODES][2];
	logic [31:0] trie_leaf[POOL_NODES];
	int unsigned trie_used;
	bit trie_filled;
	rsp_t pending_rsp[$];
	int errors = 0;
	int cycles = 0;
	logic [31:0] stored_keys[$];

	function automatic rsp_t trie_apply(req_t r);
		rsp_t o;
		int unsigned node, c;
		logic b;
		o = '0;
		case (action_t'(r.action))
			ACT_INSERT: begin
				if (trie_used + KEY_BITS > POOL_NODES - 1) begin
					o.dropped = 1'b1;
				end else begin
					node = 0;
					for (int i = KEY_BITS - 1; i >= 0; i--) begin
						b = r.key[i];
						c = trie_links[node][b];
						if (c == 0) begin
							trie_used++;
							c = trie_used;
							trie_links[c][0] = 0;
							trie_links[c][1] = 0;
							trie_links[node][b] = c;
						end
						node = c;
					end
					trie_leaf[node] = r.key;
					trie_filled = 1'b1;
				end
			end
			ACT_QUERY: begin
				if (trie_filled) begin
					node = 0;
					for (int i = KEY_BITS - 1; i >= 0; i--) begin
						b = r.key[i];
						c = trie_links[node][!b];
						if (c == 0) c = trie_links[node][b];
						node = c;
					end
					o.match_value = trie_leaf[node];
					o.found = 1'b1;
				end
			end
			ACT_CLEAR: begin
				trie_links[0][0] = 0;
				trie_links[0][1] = 0;
				trie_used = 0;
				trie_filled = 1'b0;
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic issue(req_t r);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_rsp.push_back(trie_apply(r));
	endtask

	function automatic logic [31:0] rand_key();
		logic [31:0] k;
		case ($urandom_range(0, 4))
			0: k = 32'd0;
			1: k = 32'hFFFF_FFFF;
			2: k = 32'd1 << $urandom_range(0, 31);
			default: k = $urandom;
		endcase
		return k;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("result with no transaction pending");
				errors++;
			end else begin
				if (rsp.match_value !== pending_rsp[0].match_value) begin
					$error("match_value expected %h actual %h",
						pending_rsp[0].match_value, rsp.match_value);
					errors++;
				end
				if (rsp.found !== pending_rsp[0].found) begin
					$error("found expected %b actual %b", pending_rsp[0].found, rsp.found);
					errors++;
				end
				if (rsp.dropped !== pending_rsp[0].dropped) begin
					$error("dropped expected %b actual %b",
						pending_rsp[0].dropped, rsp.dropped);
					errors++;
				end
				void'(pending_rsp.pop_front());
			end
		end
	end

	typedef struct {
		action_t act;
		logic [31:0] key;
		bit typed;
		rsp_t want;
	} stim_row_t;

	stim_row_t dir_rows[] = '{
		'{ACT_QUERY,  32'h0000_0000, 1'b1, '0},
		'{ACT_QUERY,  32'hFFFF_FFFF, 1'b1, '0},
		'{ACT_NONE,   32'h1234_5678, 1'b1, '0},
		'{ACT_INSERT, 32'h0000_0000, 1'b1, '0},
		'{ACT_QUERY,  32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b1, 1'b0}},
		'{ACT_INSERT, 32'hFFFF_FFFF, 1'b1, '0},
		'{ACT_QUERY,  32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
		'{ACT_QUERY,  32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b1, 1'b0}},
		'{ACT_INSERT, 32'hFFFF_FFFF, 1'b1, '0},
		'{ACT_INSERT, 32'h8000_0000, 1'b0, '0},
		'{ACT_INSERT, 32'h0000_0001, 1'b0, '0},
		'{ACT_QUERY,  32'h7FFF_FFFF, 1'b0, '0},
		'{ACT_QUERY,  32'hA5A5_5A5A, 1'b0, '0},
		'{ACT_NONE,   32'hFFFF_FFFF, 1'b1, '0},
		'{ACT_QUERY,  32'h0000_0001, 1'b0, '0},
		'{ACT_CLEAR,  32'hFFFF_FFFF, 1'b1, '0},
		'{ACT_QUERY,  32'h5555_5555, 1'b1, '0},
		'{ACT_INSERT, 32'h5555_5555, 1'b1, '0},
		'{ACT_QUERY,  32'h5555_5555, 1'b1, '{32'h5555_5555, 1'b1, 1'b0}},
		'{ACT_CLEAR,  32'h0000_0000, 1'b1, '0}
	};

	initial begin
		req_t r;
		int n;
		trie_used = 0;
		trie_filled = 1'b0;
		trie_links[0][0] = 0;
		trie_links[0][1] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			r.action = dir_rows[i].act;
			r.key = dir_rows[i].key;
			issue(r);
			if (dir_rows[i].typed && pending_rsp[$] != dir_rows[i].want) begin
				$error("table row %0d: predictor disagrees with typed result", i);
				errors++;
			end
		end
		n = 0;
		while (n < 1100) begin
			case ($urandom_range(0, 19))
				0: r.action = ACT_CLEAR;
				1: r.action = ACT_NONE;
				2, 3, 4, 5, 6, 7, 8, 9: r.action = ACT_INSERT;
				default: r.action = ACT_QUERY;
			endcase
			r.key = rand_key();
			// revisit stored keys so duplicates and near misses occur
			if (stored_keys.size() > 0 && $urandom_range(0, 3) == 0)
				r.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)]
					^ ($urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31)) : 32'd0);
			if (r.action == ACT_INSERT) stored_keys.push_back(r.key);
			if (r.action == ACT_CLEAR) stored_keys.delete();
			issue(r);
			n++;
		end
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
